// ----- rtl/pgc_pkg.sv -----
// Shared types, constants and elaboration-time tables for the gamma corrector.
package pgc_pkg;

	// Register reset value and the code for an exponent of exactly one (Q4.12)
	localparam logic [15:0] GAMMA_ONE = 16'd4096;
	localparam logic [15:0] GAMMA_ZERO = 16'd0;

	localparam logic [7:0] CODE_BLACK = 8'd0;
	localparam logic [7:0] CODE_FULL = 8'd255;

	// Fixed-point layout
	localparam int unsigned FRAC_BITS = 28;      // log2 fraction bits
	localparam int unsigned ONE_SH = 30;         // Q30 exponent domain
	localparam int unsigned GAMMA_FRAC = 12;
	localparam int unsigned Y_W = 31;            // log2(255/c), Q3.28
	localparam int unsigned P_W = 35;            // y * gamma, Q7.28
	localparam int unsigned U_W = FRAC_BITS + 1; // 1 - f, range (0, 1]
	localparam int unsigned X_W = 30;            // exponent argument, Q30
	localparam int unsigned TERM_W = 31;         // Taylor term, holds 1.0
	localparam int unsigned SUM_W = 32;          // Taylor sum, below 2.0
	localparam int unsigned RM_W = 31;           // reciprocal multiplier
	localparam int unsigned QF_W = 64;           // reciprocal product
	localparam logic [X_W-1:0] LN2_Q30 = 30'd744261118;

	// Terms beyond the tenth truncate to zero for any argument up to ln2
	localparam int unsigned EXP_TERMS = 10;

	// Stage 1..3, two stages per Taylor term, final scale stage
	localparam int unsigned PIPE_DEPTH = 3 + 2 * EXP_TERMS + 1;

	typedef logic [Y_W-1:0] logy_t;
	typedef logy_t logy_tbl_t [256];

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
	} pix_t;

	// log2(c) in Q3.28 by repeated squaring of the normalized mantissa
	function automatic logic [63:0] log2_q28(input int unsigned c);
		logic [63:0] m;
		logic [63:0] frac;
		int unsigned msb;
		int unsigned i;
		msb = 0;
		for (i = 1; i < 8; i++) begin
			if ((c >> i) != 0) msb = i;
		end
		m = 64'(c) << (ONE_SH - msb);
		frac = '0;
		for (i = 0; i < FRAC_BITS; i++) begin
			m = (m * m) >> ONE_SH;
			frac = frac << 1;
			if (m >= (64'd2 << ONE_SH)) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		return (64'(msb) << FRAC_BITS) | frac;
	endfunction

	// y = log2(255) - log2(c); entry 0 is never used on the datapath
	function automatic logy_tbl_t build_logy();
		logy_tbl_t t;
		logic [63:0] top;
		int unsigned c;
		top = log2_q28(255);
		t[0] = '0;
		for (c = 1; c < 256; c++) begin
			t[c] = Y_W'(top - log2_q28(c));
		end
		return t;
	endfunction

	localparam logy_tbl_t LOGY_TBL = build_logy();

endpackage

// ----- rtl/pgc_chan.sv -----
// One colour channel: log2 lookup, gamma multiply, exp2 by Taylor series, scale.
module pgc_chan (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] gamma_q,
	input  logic [7:0]  c_in,
	output logic [7:0]  c_out
);
	import pgc_pkg::*;

	localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(1) << ONE_SH;
	localparam logic [SUM_W-1:0] SUM_ONE = SUM_W'(1) << ONE_SH;
	localparam logic [U_W-1:0] U_ONE = U_W'(1) << FRAC_BITS;

	// Stage 1: table lookup and special cases
	logic [Y_W-1:0] y_s1;
	logic           spec_s1;
	logic [7:0]     val_s1;
	logic           spec_d;
	logic [7:0]     val_d;

	always_comb begin
		spec_d = 1'b1;
		val_d = CODE_BLACK;
		priority if (gamma_q == GAMMA_ONE) val_d = c_in;
		else if (gamma_q == GAMMA_ZERO) val_d = CODE_FULL;
		else if (c_in == CODE_BLACK) val_d = CODE_BLACK;
		else if (c_in == CODE_FULL) val_d = CODE_FULL;
		else spec_d = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1 <= LOGY_TBL[c_in];
			spec_s1 <= spec_d;
			val_s1 <= val_d;
		end
	end

	// Stage 2: p = y * gamma >> 12
	logic [Y_W+15:0] yg;
	logic [P_W-1:0]  p_s2;
	logic            spec_s2;
	logic [7:0]      val_s2;

	assign yg = (Y_W+16)'(y_s1) * (Y_W+16)'(gamma_q);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= yg[GAMMA_FRAC +: P_W];
			spec_s2 <= spec_s1;
			val_s2 <= val_s1;
		end
	end

	// Stage 3: split p into integer n and fraction f, x = (1 - f) * ln2
	logic [P_W-FRAC_BITS-1:0] n_int;
	logic [U_W-1:0]           u;
	logic [U_W+X_W-1:0]       xprod;
	logic                     too_small;

	// Chain registers: index 0 from stage 3, index k after Taylor term k
	logic [X_W-1:0]    x_sb    [EXP_TERMS+1];
	logic [2:0]        n_sb    [EXP_TERMS+1];
	logic              spec_sb [EXP_TERMS+1];
	logic [7:0]        val_sb  [EXP_TERMS+1];
	logic [TERM_W-1:0] term_sb [EXP_TERMS+1];
	logic [SUM_W-1:0]  sum_sb  [EXP_TERMS+1];

	assign n_int = p_s2[P_W-1:FRAC_BITS];
	assign too_small = |n_int[P_W-FRAC_BITS-1:3];
	assign u = U_ONE - {1'b0, p_s2[FRAC_BITS-1:0]};
	assign xprod = (U_W+X_W)'(u) * (U_W+X_W)'(LN2_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			x_sb[0] <= xprod[FRAC_BITS +: X_W];
			n_sb[0] <= n_int[2:0];
			spec_sb[0] <= spec_s2 | too_small;
			val_sb[0] <= spec_s2 ? val_s2 : CODE_BLACK;
		end
	end

	// Taylor terms of e^x: term = ((term * x) >> 30) / k, then accumulate
	for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
		localparam int unsigned K = j + 1;
		localparam int unsigned RS = ONE_SH + $clog2(K);
		localparam logic [63:0] RM = ((64'd1 << RS) + 64'(K) - 64'd1) / 64'(K);

		logic [TERM_W-1:0]       term_in;
		logic [SUM_W-1:0]        sum_in;
		logic [TERM_W+X_W-1:0]   tx;
		logic [QF_W-1:0]         qfull;
		logic [X_W-1:0]          quo;
		logic [X_W-1:0]          prod_sa;
		logic [SUM_W-1:0]        sum_sa;
		logic [X_W-1:0]          x_sa;
		logic [2:0]              n_sa;
		logic                    spec_sa;
		logic [7:0]              val_sa;

		if (j == 0) begin : g_first
			assign term_in = TERM_ONE;
			assign sum_in = SUM_ONE;
		end else begin : g_next
			assign term_in = term_sb[j];
			assign sum_in = sum_sb[j];
		end

		assign tx = (TERM_W+X_W)'(term_in) * (TERM_W+X_W)'(x_sb[j]);

		always_ff @(posedge clk) begin
			if (en) begin
				prod_sa <= tx[ONE_SH +: X_W];
				sum_sa <= sum_in;
				x_sa <= x_sb[j];
				n_sa <= n_sb[j];
				spec_sa <= spec_sb[j];
				val_sa <= val_sb[j];
			end
		end

		// exact floor division by k through a rounded-up reciprocal
		assign qfull = QF_W'(prod_sa) * QF_W'(RM[RM_W-1:0]);
		assign quo = qfull[RS +: X_W];

		always_ff @(posedge clk) begin
			if (en) begin
				term_sb[j+1] <= TERM_W'(quo);
				sum_sb[j+1] <= sum_sa + SUM_W'(quo);
				x_sb[j+1] <= x_sa;
				n_sb[j+1] <= n_sa;
				spec_sb[j+1] <= spec_sa;
				val_sb[j+1] <= val_sa;
			end
		end
	end

	// Final stage: r = (255 * s) >> (31 + n), clamp, merge special cases
	logic [SUM_W+7:0] scaled;
	logic [8:0]       r9;
	logic [7:0]       r8;
	logic [7:0]       cor_sf;

	assign scaled = {sum_sb[EXP_TERMS], 8'd0} - {8'd0, sum_sb[EXP_TERMS]};
	assign r9 = scaled[SUM_W+7 -: 9] >> n_sb[EXP_TERMS];
	assign r8 = r9[8] ? CODE_FULL : r9[7:0];

	always_ff @(posedge clk) begin
		if (en) begin
			cor_sf <= spec_sb[EXP_TERMS] ? val_sb[EXP_TERMS] : r8;
		end
	end

	assign c_out = cor_sf;

endmodule

// ----- rtl/pgc_skid.sv -----
// Output register with a skid stage between the pipeline and the result channel.
module pgc_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  pgc_pkg::pix_t in_data,
	output logic          ready,
	output logic          cor_valid,
	input  logic          cor_stall,
	output pgc_pkg::pix_t out_data
);
	import pgc_pkg::*;

	logic out_vld_q;
	logic skid_vld_q;
	pix_t out_data_q;
	pix_t skid_data_q;
	logic take;
	logic load_out;
	logic load_skid;

	assign ready = !skid_vld_q;
	assign take = out_vld_q && !cor_stall;
	assign load_out = !skid_vld_q && in_vld && (!out_vld_q || take);
	assign load_skid = !skid_vld_q && in_vld && out_vld_q && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_vld_q) begin
				if (take) skid_vld_q <= 1'b0;
			end else if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (load_skid) begin
				skid_vld_q <= 1'b1;
			end else if (take) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q && take) out_data_q <= skid_data_q;
		else if (load_out) out_data_q <= in_data;
		if (load_skid) skid_data_q <= in_data;
	end

	assign cor_valid = out_vld_q;
	assign out_data = out_data_q;

endmodule

// ----- rtl/pixel_gamma_correct.sv -----
// Top level: ARGB power-law gamma correction, three channel pipelines and alpha delay.
// Throughput: one pixel per clock while the skid stage is empty; the pipeline holds one beat in each of its 24 stages.
// A pixel beat passes through the 3 front stages, two stages per Taylor term of exp2
//   (10 terms) and the scale stage, then into the output register or the skid stage.
// Reset (arst_n low, asynchronous): valid bits and the skid stage clear, gamma returns to 1.0.
// The pixel side stalls only while the skid stage holds a beat.
module pixel_gamma_correct (
	input  logic        clk,
	input  logic        arst_n,
	// gamma register, Q4.12
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	// pixel channel
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic [7:0]  blue_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  red_in,
	input  logic [7:0]  alpha_in,
	// corrected channel
	output logic        cor_valid,
	input  logic        cor_stall,
	output logic [7:0]  blue_out,
	output logic [7:0]  green_out,
	output logic [7:0]  red_out,
	output logic [7:0]  alpha_out
);
	import pgc_pkg::*;

	logic [15:0]           gamma_q;
	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic [7:0]            alpha_q [PIPE_DEPTH];
	pix_t                  pipe_pix;
	pix_t                  out_pix;

	// Gamma register; to be written only while the pipeline is empty (the user's duty, not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_ONE;
		end else if (cfg_we) begin
			gamma_q <= cfg_wdata;
		end
	end

	// Whole pipeline advances together; hold everything while the skid is full
	assign pix_stall = !en;

	// Valid bits travel alongside the channel data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], pix_valid};
		end
	end

	// Alpha needs no arithmetic: delay it to line up with the colour result
	always_ff @(posedge clk) begin
		if (en) begin
			alpha_q[0] <= alpha_in;
			for (int i = 1; i < PIPE_DEPTH; i++) alpha_q[i] <= alpha_q[i-1];
		end
	end

	pgc_chan u_blue (
		.clk     (clk),
		.en      (en),
		.gamma_q (gamma_q),
		.c_in    (blue_in),
		.c_out   (pipe_pix.blue)
	);

	pgc_chan u_green (
		.clk     (clk),
		.en      (en),
		.gamma_q (gamma_q),
		.c_in    (green_in),
		.c_out   (pipe_pix.green)
	);

	pgc_chan u_red (
		.clk     (clk),
		.en      (en),
		.gamma_q (gamma_q),
		.c_in    (red_in),
		.c_out   (pipe_pix.red)
	);

	assign pipe_pix.alpha = alpha_q[PIPE_DEPTH-1];

	// Drop the last stage's beat into the output register or the skid stage
	pgc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_q[PIPE_DEPTH-1] && en),
		.in_data   (pipe_pix),
		.ready     (en),
		.cor_valid (cor_valid),
		.cor_stall (cor_stall),
		.out_data  (out_pix)
	);

	assign blue_out = out_pix.blue;
	assign green_out = out_pix.green;
	assign red_out = out_pix.red;
	assign alpha_out = out_pix.alpha;

`ifndef ASSERT_OFF
	// a full skid stage always sits behind a presented result
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> cor_valid)
		else $error("pixel side stalled with no result presented");

	// once the result is taken, the skid beat moves up and the pixel side reopens
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_stall && !cor_stall) |=> (cor_valid && !pix_stall))
		else $error("skid stage did not drain after the result beat was taken");

	// the skid stage fills only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_stall) |-> $past(cor_valid && cor_stall))
		else $error("pixel side stalled without a stalled result");
`endif

endmodule

// ----- tb/sv/tb_pixel_gamma_correct.sv -----
// Self-checking testbench for pixel_gamma_correct: directed table, random pixels, predictor.
`timescale 1ns / 100ps

module tb_pixel_gamma_correct;
	import pgc_pkg::*;

	// Depth of the result pipeline; the final wait adds slack on top
	localparam int PIPE_LAT = 24;
	localparam int QUIET_LIMIT = 4000;    // cycles with no beat on either side
	localparam int EXP_ORDER = 16;        // Taylor terms of e^x in the predictor
	localparam int REPORT_MAX = 10;
	localparam int DIR_ROWS = 20;

	// One row of the directed table: exponent, pixel, and the result where it is obvious
	typedef struct packed {
		logic [15:0] gamma;
		pix_t        pix;
		logic        known;
		pix_t        result;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        pix_valid;
	logic        pix_stall;
	logic [7:0]  blue_in;
	logic [7:0]  green_in;
	logic [7:0]  red_in;
	logic [7:0]  alpha_in;
	logic        cor_valid;
	logic        cor_stall;
	logic [7:0]  blue_out;
	logic [7:0]  green_out;
	logic [7:0]  red_out;
	logic [7:0]  alpha_out;

	// Testbench copy of the exponent register, starts at its reset value
	logic [15:0] gamma_now;
	// Corrected pixels still owed by the block, oldest first
	pix_t        pending_pix[$];
	int          err_cnt;
	int          quiet_cycles;
	int          src_idle_pct;
	int          sink_stall_pct;

	// Directed rows: unit gamma right after reset, zero gamma, the largest exponent,
	// black and full bytes, tiny results, exponents just around one, smallest nonzero
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{16'd4096,  '{8'd0,   8'd128, 8'd255, 8'h00}, 1'b1, '{8'd0,   8'd128, 8'd255, 8'h00}},
		'{16'd4096,  '{8'd255, 8'd1,   8'd77,  8'hFF}, 1'b1, '{8'd255, 8'd1,   8'd77,  8'hFF}},
		'{16'd0,     '{8'd0,   8'd100, 8'd255, 8'hA5}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'hA5}},
		'{16'd0,     '{8'd1,   8'd254, 8'd128, 8'h5A}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'h5A}},
		'{16'd65535, '{8'd0,   8'd255, 8'd1,   8'hFF}, 1'b1, '{8'd0,   8'd255, 8'd0,   8'hFF}},
		'{16'd65535, '{8'd254, 8'd200, 8'd128, 8'h00}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
		'{16'd8192,  '{8'd0,   8'd255, 8'd0,   8'h0F}, 1'b1, '{8'd0,   8'd255, 8'd0,   8'h0F}},
		'{16'd8192,  '{8'd16,  8'd64,  8'd128, 8'hF0}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
		'{16'd8192,  '{8'd254, 8'd1,   8'd200, 8'h33}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
		'{16'd2048,  '{8'd1,   8'd2,   8'd254, 8'hCC}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
		'{16'd2048,  '{8'd0,   8'd255, 8'd64,  8'h3C}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
		'{16'd1,     '{8'd1,   8'd128, 8'd254, 8'h81}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
		'{16'd4095,  '{8'd1,   8'd127, 8'd254, 8'h7E}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
		'{16'd4097,  '{8'd1,   8'd127, 8'd254, 8'hE7}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
		'{16'd32768, '{8'd200, 8'd230, 8'd250, 8'h18}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
		'{16'd32768, '{8'd1,   8'd2,   8'd3,   8'h42}, 1'b1, '{8'd0,   8'd0,   8'd0,   8'h42}},
		'{16'd16384, '{8'd8,   8'd16,  8'd32,  8'h99}, 1'b1, '{8'd0,   8'd0,   8'd0,   8'h99}},
		'{16'd16384, '{8'd240, 8'd250, 8'd128, 8'h66}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
		'{16'd12288, '{8'd255, 8'd0,   8'd255, 8'h00}, 1'b1, '{8'd255, 8'd0,   8'd255, 8'h00}},
		'{16'd4096,  '{8'h55,  8'hAA,  8'h0F,  8'hF0}, 1'b1, '{8'h55,  8'hAA,  8'h0F,  8'hF0}}
	};

	pixel_gamma_correct DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.blue_in   (blue_in),
		.green_in  (green_in),
		.red_in    (red_in),
		.alpha_in  (alpha_in),
		.cor_valid (cor_valid),
		.cor_stall (cor_stall),
		.blue_out  (blue_out),
		.green_out (green_out),
		.red_out   (red_out),
		.alpha_out (alpha_out)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// log2 of a byte 1..255 in Q3.28: normalize, then square the mantissa once per bit
	function automatic logic [63:0] byte_log2(input logic [7:0] c);
		logic [63:0] mant;
		logic [63:0] bits;
		int unsigned lead;
		lead = 0;
		while (lead < 7 && (c >> (lead + 1)) != 0) lead++;
		mant = 64'(c) << (ONE_SH - lead);
		bits = '0;
		repeat (FRAC_BITS) begin
			mant = (mant * mant) >> ONE_SH;
			bits = bits << 1;
			if (mant >= (64'd2 << ONE_SH)) begin
				mant = mant >> 1;
				bits[0] = 1'b1;
			end
		end
		return (64'(lead) << FRAC_BITS) | bits;
	endfunction

	// e^arg for arg in Q30 up to ln2, by a truncated Taylor series; result in Q30
	function automatic logic [63:0] exp_series(input logic [63:0] arg);
		logic [63:0] term;
		logic [63:0] acc;
		int k;
		term = 64'd1 << ONE_SH;
		acc = term;
		for (k = 1; k <= EXP_ORDER; k++) begin
			term = ((term * arg) >> ONE_SH) / 64'(k);
			acc = acc + term;
		end
		return acc;
	endfunction

	// floor(255 * (c/255)^g) with g in Q4.12, split as 2^-p = 2^(1-f) * 2^-(n+1)
	function automatic logic [7:0] gamma_byte(input logic [7:0] c, input logic [15:0] g);
		logic [63:0] log_gap;
		logic [63:0] scaled;
		logic [63:0] whole;
		logic [63:0] part;
		logic [63:0] arg;
		logic [63:0] level;
		if (g == GAMMA_ONE) return c;
		if (g == GAMMA_ZERO) return CODE_FULL;
		if (c == CODE_BLACK) return CODE_BLACK;
		if (c == CODE_FULL) return CODE_FULL;
		log_gap = byte_log2(CODE_FULL) - byte_log2(c);
		scaled = (log_gap * 64'(g)) >> GAMMA_FRAC;
		whole = scaled >> FRAC_BITS;
		if (whole >= 64'd8) return CODE_BLACK;
		part = (64'd1 << FRAC_BITS) - (scaled & ((64'd1 << FRAC_BITS) - 64'd1));
		arg = (part * 64'(LN2_Q30)) >> FRAC_BITS;
		level = (64'd255 * exp_series(arg)) >> (64'd31 + whole);
		if (level > 64'd255) level = 64'd255;
		return level[7:0];
	endfunction

	function automatic pix_t corrected_pixel(input pix_t px, input logic [15:0] g);
		pix_t res;
		res.blue = gamma_byte(px.blue, g);
		res.green = gamma_byte(px.green, g);
		res.red = gamma_byte(px.red, g);
		res.alpha = px.alpha;
		return res;
	endfunction

	// Lean on the corner codes: black, full, the bottom and the top of the range
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return CODE_BLACK;
			1: return CODE_FULL;
			2: return 8'($urandom_range(1, 3));
			3: return 8'($urandom_range(250, 254));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mix of zero, unit and maximum exponent with typical and fully random ones
	function automatic logic [15:0] pick_gamma();
		case ($urandom_range(0, 6))
			0: return GAMMA_ZERO;
			1: return 16'hFFFF;
			2: return GAMMA_ONE;
			3: return 16'($urandom_range(1, 4095));
			4: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(1024, 12288));
		endcase
	endfunction

	// Present one pixel beat, idling first at the current rate, and hold it until
	// accepted. Valid stays high on return so back-to-back beats never glitch.
	task automatic send_pixel(input pix_t px, input pix_t want);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		blue_in <= px.blue;
		green_in <= px.green;
		red_in <= px.red;
		alpha_in <= px.alpha;
		do @(posedge clk); while (pix_stall);
		pending_pix.push_back(want);
	endtask

	// Drop valid, drain every owed result, then write the exponent while idle
	task automatic load_gamma(input logic [15:0] g);
		pix_valid <= 1'b0;
		while (pending_pix.size() != 0) @(posedge clk);
		cfg_wdata <= g;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		gamma_now = g;
	endtask

	// Receiver side: stall at the current rate, one decision per clock
	always @(posedge clk) begin
		cor_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	// Compare every accepted result beat against the oldest owed pixel
	always @(posedge clk) begin : result_check
		pix_t want;
		pix_t got;
		if (arst_n && cor_valid && !cor_stall) begin
			got = {blue_out, green_out, red_out, alpha_out};
			if (pending_pix.size() == 0) begin
				err_cnt++;
				if (err_cnt <= REPORT_MAX)
					$display("unexpected result beat: b=%0d g=%0d r=%0d a=%0d",
						got.blue, got.green, got.red, got.alpha);
			end else begin
				want = pending_pix.pop_front();
				if (got !== want) begin
					err_cnt++;
					if (err_cnt <= REPORT_MAX)
						$display("mismatch: expected b=%0d g=%0d r=%0d a=%0d, got b=%0d g=%0d r=%0d a=%0d",
							want.blue, want.green, want.red, want.alpha,
							got.blue, got.green, got.red, got.alpha);
				end
			end
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (cor_valid && !cor_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no beat for %0d cycles", quiet_cycles);
			$display("pixel_gamma_correct verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int src_pct [3];
		int sink_pct [3];
		int mode;
		int phase;
		int n;
		int i;
		pix_t px;
		src_pct = '{26, 59, 0};
		sink_pct = '{59, 26, 0};

		// Hold every input at a known value from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pix_valid = 1'b0;
		blue_in = '0;
		green_in = '0;
		red_in = '0;
		alpha_in = '0;
		cor_stall = 1'b0;
		err_cnt = 0;
		quiet_cycles = 0;
		gamma_now = GAMMA_ONE;
		src_idle_pct = src_pct[0];
		sink_stall_pct = sink_pct[0];

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; rows without a typed result go through the predictor
		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].gamma != gamma_now) load_gamma(dir_rows[i].gamma);
			send_pixel(dir_rows[i].pix, dir_rows[i].known ? dir_rows[i].result
				: corrected_pixel(dir_rows[i].pix, gamma_now));
		end

		// Random part: three idle patterns, several exponents each
		for (mode = 0; mode < 3; mode++) begin
			src_idle_pct = src_pct[mode];
			sink_stall_pct = sink_pct[mode];
			for (phase = 0; phase < 5; phase++) begin
				load_gamma(pick_gamma());
				n = $urandom_range(100, 170);
				repeat (n) begin
					px.blue = pick_byte();
					px.green = pick_byte();
					px.red = pick_byte();
					px.alpha = 8'($urandom_range(0, 255));
					send_pixel(px, corrected_pixel(px, gamma_now));
				end
			end
		end

		// Wait out the owed results, then let the pipeline run empty before the verdict
		pix_valid <= 1'b0;
		while (pending_pix.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 8) @(posedge clk);

		if (pending_pix.size() != 0) begin
			$display("%0d results never arrived", pending_pix.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("pixel_gamma_correct verification clean");
		else
			$display("pixel_gamma_correct verification failed");
		$finish;
	end

endmodule

// ----- pixel_gamma_correct.f -----
rtl/pgc_pkg.sv
rtl/pgc_chan.sv
rtl/pgc_skid.sv
rtl/pixel_gamma_correct.sv
tb/sv/tb_pixel_gamma_correct.sv
